[sv/wst_pkg.sv]
// Shared types, register indexes and reset values for the waveform segment block.
package wst_pkg;

  localparam int DEFAULT_INDEX_BITS = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_H  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_V  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RED      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 3'd7;

  localparam logic [31:0] RST_X_ORIGIN = 32'd0;
  localparam logic [31:0] RST_X_STEP   = 32'd65536;
  localparam logic [30:0] RST_WIDTH    = 31'd65536;
  localparam logic [15:0] RST_COLOR    = 16'hFFFF;

  localparam logic [2:0] VERT_LAST = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_POS, ST_NORM, ST_SQA, ST_SQB, ST_SQRT,
    ST_DIVI, ST_DIV, ST_SCX, ST_SCY, ST_EMIT
  } wst_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_POS, OP_NORM, OP_SQA, OP_SQB, OP_SQRT,
    OP_DIVI, OP_DIV, OP_SCX, OP_SCY, OP_EMIT
  } wst_op_t;

  typedef struct packed {
    wst_op_t op;
  } wst_cmd_t;

  typedef struct packed {
    logic prime;        // incoming sample only primes the block
    logic zero_len;
    logic norm_done;
    logic sqrt_done;    // current root iteration is the last one
    logic div_done;     // current divide iteration is the last one
    logic out_free;
    logic corner_last;
  } wst_status_t;

endpackage

[sv/wst_ctrl.sv]
// Sequencer for the segment datapath: one sample at a time.
module wst_ctrl
  import wst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  wst_status_t status,
  output logic        in_stall,
  output wst_cmd_t    cmd
);

  wst_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && !status.prime) state_next = ST_MUL;
      ST_MUL:  state_next = ST_POS;
      ST_POS:  state_next = ST_NORM;
      ST_NORM: begin
        if (status.zero_len) state_next = ST_SCX;
        else if (status.norm_done) state_next = ST_SQA;
      end
      ST_SQA:  state_next = ST_SQB;
      ST_SQB:  state_next = ST_SQRT;
      ST_SQRT: if (status.sqrt_done) state_next = ST_DIVI;
      ST_DIVI: state_next = ST_DIV;
      ST_DIV:  if (status.div_done) state_next = ST_SCX;
      ST_SCX:  state_next = ST_SCY;
      ST_SCY:  state_next = ST_EMIT;
      ST_EMIT: if (status.out_free && status.corner_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_MUL:  cmd.op = OP_MUL;
      ST_POS:  cmd.op = OP_POS;
      ST_NORM: if (!status.zero_len && !status.norm_done) cmd.op = OP_NORM;
      ST_SQA:  cmd.op = OP_SQA;
      ST_SQB:  cmd.op = OP_SQB;
      ST_SQRT: cmd.op = OP_SQRT;
      ST_DIVI: cmd.op = OP_DIVI;
      ST_DIV:  cmd.op = OP_DIV;
      ST_SCX:  cmd.op = OP_SCX;
      ST_SCY:  cmd.op = OP_SCY;
      ST_EMIT: if (status.out_free) cmd.op = OP_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

[sv/wst_dp.sv]
// Datapath: config registers, positions, normalization, root, divide, vertex output.
module wst_dp
  import wst_pkg::*;
#(
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic signed [31:0]     sample_value,
  input  logic [INDEX_BITS-1:0]  sample_index,
  input  logic                   restart,
  input  wst_cmd_t               cmd,
  output wst_status_t            status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     vert_x,
  output logic signed [31:0]     vert_y,
  output logic [2:0]             corner,
  output logic [15:0]            red,
  output logic [15:0]            green,
  output logic [15:0]            blue,
  output logic [15:0]            alpha,
  output logic                   last
);

  localparam int PW = INDEX_BITS + 33;  // step * (index as signed)
  localparam int XW = INDEX_BITS + 35;  // positions before saturation

  logic signed [31:0] x_origin, x_step;
  logic [30:0] width_h, width_v;
  logic [15:0] col_r, col_g, col_b, col_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin <= RST_X_ORIGIN;
      x_step   <= RST_X_STEP;
      width_h  <= RST_WIDTH;
      width_v  <= RST_WIDTH;
      col_r    <= RST_COLOR;
      col_g    <= RST_COLOR;
      col_b    <= RST_COLOR;
      col_a    <= RST_COLOR;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        CFG_X_ORIGIN: x_origin <= cfg_data;
        CFG_X_STEP:   x_step <= cfg_data;
        CFG_WIDTH_H:  width_h <= cfg_data[30:0];
        CFG_WIDTH_V:  width_v <= cfg_data[30:0];
        CFG_RED:      col_r <= cfg_data[15:0];
        CFG_GREEN:    col_g <= cfg_data[15:0];
        CFG_BLUE:     col_b <= cfg_data[15:0];
        CFG_ALPHA:    col_a <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] prior_value;
  logic have_prior;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_value <= '0;
      have_prior <= 1'b0;
    end else if (cmd.op == OP_LOAD) begin
      prior_value <= sample_value;
      have_prior <= 1'b1;
    end
  end

  // working registers
  logic [INDEX_BITS-1:0] idx;
  logic signed [31:0] cy, py;
  logic signed [32:0] dy;
  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] cx, px;
  logic [32:0] ax, ay;
  logic [59:0] sq;
  logic [60:0] sn, rr, bitr;
  logic [30:0] rx, ry, qx, qy;
  logic [4:0] cnt;
  logic signed [31:0] ox, oy;
  logic [2:0] corner_cnt;

  logic signed [32:0] step_w;
  logic [32:0] step_mag, dy_mag, mo;
  logic [61:0] root_try;
  logic root_ge;
  logic [30:0] len;
  logic [31:0] rx2, ry2;
  logic gex, gey, gex0, gey0;
  logic [30:0] sc_w, sc_q;
  logic [62:0] sc_prod;
  logic [31:0] sc_mag;
  logic sc_neg;

  always_comb begin
    step_w = 33'(x_step);
    step_mag = step_w[32] ? 33'(-step_w) : 33'(step_w);
    dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
    mo = ax | ay;
    root_try = {1'b0, rr} + {1'b0, bitr};
    root_ge = {1'b0, sn} >= root_try;
    len = rr[30:0];
    gex0 = {1'b0, ax[29:0]} >= len;
    gey0 = {1'b0, ay[29:0]} >= len;
    rx2 = {rx, 1'b0};
    ry2 = {ry, 1'b0};
    gex = rx2 >= {1'b0, len};
    gey = ry2 >= {1'b0, len};
    // one shared multiplier for both offsets
    sc_w = (cmd.op == OP_SCX) ? width_h : width_v;
    sc_q = (cmd.op == OP_SCX) ? qy : qx;
    sc_prod = 63'(sc_w) * 63'(sc_q) + 63'(64'h4000_0000);
    sc_mag = sc_prod[62:31];
    // x offset is along -uy, y offset along ux
    sc_neg = (cmd.op == OP_SCX) ? (!dy[32] && (dy != '0)) : x_step[31];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        cy <= sample_value;
        py <= prior_value;
        idx <= sample_index;
      end
      OP_MUL: begin
        prod <= PW'(x_step) * PW'($signed({1'b0, idx}));
        dy <= 33'(cy) - 33'(py);
      end
      OP_POS: begin
        cx <= XW'(prod) + XW'(x_origin);
        px <= XW'(prod) - XW'(x_step) + XW'(x_origin);
        ax <= step_mag;
        ay <= dy_mag;
        qx <= '0;
        qy <= '0;
      end
      OP_NORM: begin
        // bring the larger magnitude's top bit to bit 29
        if (mo[32:30] != 3'd0) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (mo[29:22] == 8'd0) begin
          ax <= ax << 8;
          ay <= ay << 8;
        end else begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      OP_SQA: sq <= 60'(ax[29:0]) * 60'(ax[29:0]);
      OP_SQB: begin
        sn <= 61'(sq) + 61'(ay[29:0]) * 61'(ay[29:0]);
        rr <= '0;
        bitr <= 61'(1) << 60;
      end
      OP_SQRT: begin
        if (root_ge) begin
          sn <= 61'({1'b0, sn} - root_try);
          rr <= 61'((rr >> 1) + bitr);
        end else begin
          rr <= rr >> 1;
        end
        bitr <= bitr >> 2;
      end
      OP_DIVI: begin
        // quotient can reach 1.0 exactly, so its top bit comes first
        qx <= {30'd0, gex0};
        qy <= {30'd0, gey0};
        rx <= gex0 ? 31'({1'b0, ax[29:0]} - len) : {1'b0, ax[29:0]};
        ry <= gey0 ? 31'({1'b0, ay[29:0]} - len) : {1'b0, ay[29:0]};
        cnt <= 5'd29;
      end
      OP_DIV: begin
        qx <= {qx[29:0], gex};
        qy <= {qy[29:0], gey};
        rx <= gex ? 31'(rx2 - {1'b0, len}) : rx2[30:0];
        ry <= gey ? 31'(ry2 - {1'b0, len}) : ry2[30:0];
        cnt <= cnt - 5'd1;
      end
      OP_SCX: ox <= sc_neg ? -$signed(sc_mag) : $signed(sc_mag);
      OP_SCY: oy <= sc_neg ? -$signed(sc_mag) : $signed(sc_mag);
      default: ;
    endcase
  end

  // vertex select and saturation
  logic use_cur, plus;
  logic signed [XW:0] sum_x;
  logic signed [33:0] sum_y;
  logic signed [31:0] sat_x, sat_y;

  always_comb begin
    use_cur = (corner_cnt == 3'd1) || (corner_cnt == 3'd4) || (corner_cnt == 3'd5);
    plus = (corner_cnt == 3'd2) || (corner_cnt == 3'd3) || (corner_cnt == 3'd5);
    sum_x = plus ? ((XW+1)'(use_cur ? cx : px) + (XW+1)'(ox))
                 : ((XW+1)'(use_cur ? cx : px) - (XW+1)'(ox));
    sum_y = plus ? (34'(use_cur ? cy : py) + 34'(oy))
                 : (34'(use_cur ? cy : py) - 34'(oy));
    if ((&sum_x[XW:31]) || !(|sum_x[XW:31])) sat_x = sum_x[31:0];
    else sat_x = sum_x[XW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if ((&sum_y[33:31]) || !(|sum_y[33:31])) sat_y = sum_y[31:0];
    else sat_y = sum_y[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      corner_cnt <= '0;
    end else begin
      // a vertex left over from the previous sample may still be waiting
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == OP_SCY) begin
        corner_cnt <= '0;
      end else if (cmd.op == OP_EMIT) begin
        corner_cnt <= corner_cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      vert_x <= sat_x;
      vert_y <= sat_y;
      corner <= corner_cnt;
      last <= (corner_cnt == VERT_LAST);
      red <= col_r;
      green <= col_g;
      blue <= col_b;
      alpha <= col_a;
    end
  end

  always_comb begin
    status.prime = restart || !have_prior;
    status.zero_len = (ax == '0) && (ay == '0);
    status.norm_done = (mo[32:29] == 4'b0001);
    status.sqrt_done = bitr[0];
    status.div_done = (cnt == 5'd0);
    status.out_free = !out_valid || !out_stall;
    status.corner_last = (corner_cnt == VERT_LAST);
  end

endmodule

[sv/waveform_segment_to_triangles.sv]
// A restart sample (or the first one) only primes the block and emits nothing.
// A joined sample passes through multiply, position, normalize, squaring, root,
// divide and offset states before its vertices; a zero-length one skips to offsets.
// Six vertices follow at one per cycle while the output does not stall.
// The next sample is accepted only after the sixth vertex has been issued.
// Synchronous reset restores the register defaults and forgets the prior sample.
module waveform_segment_to_triangles
  import wst_pkg::*;
#(
  parameter int INDEX_BITS = DEFAULT_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    sample_value,
  input  logic [INDEX_BITS-1:0] sample_index,
  input  logic                  restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    vert_x,
  output logic signed [31:0]    vert_y,
  output logic [2:0]            corner,
  output logic [15:0]           red,
  output logic [15:0]           green,
  output logic [15:0]           blue,
  output logic [15:0]           alpha,
  output logic                  last
);

  wst_cmd_t cmd;
  wst_status_t status;

  wst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  wst_dp #(
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_value     (sample_value),
    .sample_index     (sample_index),
    .restart          (restart),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .vert_x           (vert_x),
    .vert_y           (vert_y),
    .corner           (corner),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .alpha            (alpha),
    .last             (last)
  );

endmodule

[tb/waveform_segment_to_triangles_tb.sv]
// Self-checking testbench for the waveform segment to triangles block.
module waveform_segment_to_triangles_tb;
  import wst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [2:0] crn;
    logic [15:0] r, g, b, a;
    logic lst;
  } vertex_t;

  // Expected vertices plus a small integer model of the segment geometry.
  class vertex_scoreboard;
    vertex_t pending[$];
    int errors;
    logic [31:0] origin, step;
    logic [30:0] wh, wv;
    logic [15:0] col[4];
    logic [31:0] prev_y;
    bit primed;

    function new();
      reset_state();
      errors = 0;
    endfunction

    function void reset_state();
      origin = RST_X_ORIGIN;
      step = RST_X_STEP;
      wh = RST_WIDTH;
      wv = RST_WIDTH;
      foreach (col[i]) col[i] = RST_COLOR;
      prev_y = 0;
      primed = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_X_ORIGIN: origin = d;
        CFG_X_STEP: step = d;
        CFG_WIDTH_H: wh = d[30:0];
        CFG_WIDTH_V: wv = d[30:0];
        CFG_RED: col[0] = d[15:0];
        CFG_GREEN: col[1] = d[15:0];
        CFG_BLUE: col[2] = d[15:0];
        CFG_ALPHA: col[3] = d[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp_pos(longint v);
      longint lim;
      lim = 64'sd1 <<< 62;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
        if (n >= r + bt) begin
          n -= r + bt;
          r = (r >> 1) + bt;
        end else r >>= 1;
        bt >>= 2;
      end
      return r;
    endfunction

    function longint half_scale(logic [30:0] w, longint u);
      longint unsigned m;
      longint r;
      m = (u < 0) ? -u : u;
      r = longint'(({33'd0, w} * m + (64'd1 << 30)) >> 31);
      return (u < 0) ? -r : r;
    endfunction

    function void note_sample(logic [31:0] val, logic [23:0] idx, logic rs);
      longint st, org, i, px, cx, py, cy, dy, ux, uy, ox, oy;
      longint unsigned ax, ay, m, len;
      longint vx[6], vy[6];
      int p;
      vertex_t v;
      if (rs || !primed) begin
        prev_y = val;
        primed = 1;
        return;
      end
      st = longint'(signed'(step));
      org = longint'(signed'(origin));
      i = longint'({40'd0, idx});
      px = clamp_pos(st * (i - 1) + org);
      cx = clamp_pos(st * i + org);
      py = longint'(signed'(prev_y));
      cy = longint'(signed'(val));
      dy = cy - py;
      prev_y = val;
      ax = (st < 0) ? -st : st;
      ay = (dy < 0) ? -dy : dy;
      m = (ax > ay) ? ax : ay;
      ux = 0;
      uy = 0;
      if (m != 0) begin
        p = 0;
        while ((m >> p) > 1) p++;
        if (p > 29) begin
          ax >>= (p - 29);
          ay >>= (p - 29);
        end else begin
          ax <<= (29 - p);
          ay <<= (29 - p);
        end
        len = root(ax * ax + ay * ay);
        ux = longint'((ax << 30) / len);
        uy = longint'((ay << 30) / len);
        if (st < 0) ux = -ux;
        if (dy < 0) uy = -uy;
      end
      ox = half_scale(wh, -uy);
      oy = half_scale(wv, ux);
      vx[0] = px - ox; vy[0] = py - oy;
      vx[1] = cx - ox; vy[1] = cy - oy;
      vx[2] = px + ox; vy[2] = py + oy;
      vx[3] = px + ox; vy[3] = py + oy;
      vx[4] = cx - ox; vy[4] = cy - oy;
      vx[5] = cx + ox; vy[5] = cy + oy;
      for (int k = 0; k < 6; k++) begin
        v.x = sat(vx[k]);
        v.y = sat(vy[k]);
        v.crn = k[2:0];
        v.r = col[0];
        v.g = col[1];
        v.b = col[2];
        v.a = col[3];
        v.lst = (k[2:0] == VERT_LAST);
        pending.push_back(v);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_vertex(vertex_t got);
      vertex_t w;
      if (pending.size() == 0) begin
        report("unexpected vertex", got.x, 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.x !== w.x) report("vert_x", got.x, w.x);
      if (got.y !== w.y) report("vert_y", got.y, w.y);
      if (got.crn !== w.crn) report("corner", 32'(got.crn), 32'(w.crn));
      if (got.r !== w.r) report("red", 32'(got.r), 32'(w.r));
      if (got.g !== w.g) report("green", 32'(got.g), 32'(w.g));
      if (got.b !== w.b) report("blue", 32'(got.b), 32'(w.b));
      if (got.a !== w.a) report("alpha", 32'(got.a), 32'(w.a));
      if (got.lst !== w.lst) report("last", 32'(got.lst), 32'(w.lst));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write_enable = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_X_ORIGIN;
  logic [CFG_DATA_W-1:0] cfg_data = 0;
  logic in_valid = 0, in_stall;
  logic signed [31:0] sample_value = 0;
  logic [DEFAULT_INDEX_BITS-1:0] sample_index = 0;
  logic restart = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] vert_x, vert_y;
  logic [2:0] corner;
  logic [15:0] red, green, blue, alpha;
  logic last;

  vertex_scoreboard sb;
  int cycles = 0;
  bit hold_off = 0;
  bit gaps_on = 1;
  localparam int CYCLE_LIMIT = 400000;

  waveform_segment_to_triangles dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: a random wait per vertex, plus a long hold-off when requested.
  initial begin
    int w;
    vertex_t v;
    sb = new();
    w = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) begin
        v.x = vert_x; v.y = vert_y; v.crn = corner;
        v.r = red; v.g = green; v.b = blue; v.a = alpha; v.lst = last;
        sb.check_vertex(v);
        w = gaps_on ? $urandom_range(0, 13) : 0;
        if ($urandom_range(0, 3) == 0) w = 0;
      end
      if (hold_off) out_stall <= 1;
      else if (w > 0) begin
        out_stall <= 1;
        w--;
      end else out_stall <= 0;
    end
  end

  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_write_enable <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(posedge clk);
    cfg_write_enable <= 0;
  endtask

  task send_sample(logic [31:0] val, logic [23:0] idx, logic rs);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    repeat (gap) begin
      @(posedge clk);
      in_valid <= 0;
    end
    @(posedge clk);
    in_valid <= 1;
    sample_value <= val;
    sample_index <= idx;
    restart <= rs;
    do @(posedge clk); while (in_stall);
    sb.note_sample(val, idx, rs);
    in_valid <= 0;
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 9) : 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] y;
    logic [23:0] ix;
    #1;
    repeat (3) @(posedge clk);
    rst <= 0;
    // defaults after reset
    send_sample(0, 0, 0);
    send_sample(32'h10000, 1, 0);
    send_sample(32'h10000, 2, 0);
    send_sample(32'h7fffffff, 24'hffffff, 0);
    send_sample(32'h80000000, 0, 0);
    send_sample(5, 3, 1);
    send_sample(5, 4, 0);
    drain();
    // zero step: zero-length and vertical segments, extreme widths
    write_cfg(CFG_X_STEP, 0);
    write_cfg(CFG_WIDTH_H, 32'hffffffff);
    write_cfg(CFG_WIDTH_V, 32'h7fffffff);
    write_cfg(CFG_RED, 32'hffff0000);
    write_cfg(CFG_GREEN, 32'h1234);
    write_cfg(CFG_BLUE, 0);
    write_cfg(CFG_ALPHA, 32'h8000);
    send_sample(100, 9, 0);
    send_sample(100, 10, 0);
    send_sample(32'h80000000, 11, 0);
    send_sample(32'h7fffffff, 12, 0);
    drain();
    write_cfg(CFG_X_STEP, 32'h80000000);
    write_cfg(CFG_X_ORIGIN, 32'h7fffffff);
    write_cfg(CFG_WIDTH_H, 0);
    write_cfg(CFG_WIDTH_V, 0);
    send_sample(0, 24'hffffff, 0);
    send_sample(1, 0, 0);
    drain();
    write_cfg(CFG_X_STEP, 32'h7fffffff);
    write_cfg(CFG_X_ORIGIN, 32'h80000000);
    send_sample(32'hffffffff, 24'h800000, 0);
    send_sample(32'h12345678, 24'h7fffff, 0);
    drain();
    // fill the block while the receiver holds off
    gaps_on = 0;
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 5; k++) send_sample($urandom, 24'($urandom), 0);
    join
    gaps_on = 1;
    drain();
    // random phases with random register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_X_ORIGIN, (ph == 5) ? 32'h80000000 : $urandom);
      write_cfg(CFG_X_STEP, (ph < 3) ? $urandom_range(0, 32'h40000) - 32'h20000 : $urandom);
      write_cfg(CFG_WIDTH_H, (ph == 4) ? 32'h7fffffff : $urandom);
      write_cfg(CFG_WIDTH_V, (ph == 3) ? 32'h0 : $urandom);
      write_cfg(CFG_RED, $urandom);
      write_cfg(CFG_GREEN, $urandom);
      write_cfg(CFG_BLUE, $urandom);
      write_cfg(CFG_ALPHA, $urandom);
      gaps_on = (ph != 2);
      ix = 24'($urandom);
      for (int k = 0; k < 36; k++) begin
        if ($urandom_range(0, 9) == 0) ix = 24'($urandom);
        else ix = ix + 24'd1;
        y = (ph < 3) ? $urandom_range(0, 32'h100000) - 32'h80000 : rand_value();
        send_sample(y, ix, $urandom_range(0, 11) == 0);
      end
      gaps_on = 1;
      drain();
    end
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
